### hdl/scik_pkg.sv
package scik_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int CORDIC_ITERS_DEF = 18;
  localparam int ATAN_LEN         = 24;
  localparam int ANG_SHIFT        = 30 - FRAC_BITS;

  // CORDIC datapath widths: x/y hold inputs scaled by 2^20 plus gain growth.
  localparam int XW = 44;
  localparam int ZW = 38;

  localparam logic signed [ZW-1:0] PI_Q30      = 38'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 38'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 38'sd6746518852;
  localparam logic signed [XW-1:0] GAIN_Q30    = 44'sd652032874;

  localparam logic [17:0] LINK1_RST       = 18'd32768;
  localparam logic [17:0] LINK2_RST       = 18'd26214;
  localparam logic [15:0] ROT_STEP_RST    = 16'd3277;
  localparam logic [15:0] LIN_STEP_RST    = 16'd1638;
  localparam logic [15:0] GRIP_STEP_RST   = 16'd164;
  localparam logic [15:0] GRIP_TRAVEL_RST = 16'd1966;

  typedef enum logic [2:0] {
    CFG_LINK1       = 3'd0,
    CFG_LINK2       = 3'd1,
    CFG_ROT_STEP    = 3'd2,
    CFG_LIN_STEP    = 3'd3,
    CFG_GRIP_STEP   = 3'd4,
    CFG_GRIP_TRAVEL = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TICK, ST_NUM, ST_CHK, ST_DIV, ST_C2SQ, ST_SQRT, ST_KMUL,
    ST_ATAN_EL, ST_ATAN_T1, ST_ATAN_T2, ST_GOAL, ST_ROT1, ST_ROT2, ST_FKMUL, ST_OUT
  } st_t;

  typedef enum logic [2:0] {
    C_IDLE, C_REDUCE, C_WRAP, C_FOLD, C_ITER, C_DONE
  } cst_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cord_req_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:    return 32'd843314857;
      5'd1:    return 32'd497837829;
      5'd2:    return 32'd263043837;
      5'd3:    return 32'd133525159;
      5'd4:    return 32'd67021687;
      5'd5:    return 32'd33543516;
      5'd6:    return 32'd16775851;
      5'd7:    return 32'd8388437;
      5'd8:    return 32'd4194283;
      5'd9:    return 32'd2097149;
      5'd10:   return 32'd1048576;
      5'd11:   return 32'd524288;
      5'd12:   return 32'd262144;
      5'd13:   return 32'd131072;
      5'd14:   return 32'd65536;
      5'd15:   return 32'd32768;
      5'd16:   return 32'd16384;
      5'd17:   return 32'd8192;
      5'd18:   return 32'd4096;
      5'd19:   return 32'd2048;
      5'd20:   return 32'd1024;
      5'd21:   return 32'd512;
      5'd22:   return 32'd256;
      5'd23:   return 32'd128;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic signed [20:0] sat21(input logic signed [55:0] v);
    if (v > 56'sd1048575) begin
      return 21'sd1048575;
    end else if (v < -56'sd1048576) begin
      return 21'sh100000;
    end else begin
      return v[20:0];
    end
  endfunction

  // Move cur toward goal by at most step.
  function automatic logic signed [21:0] approach(input logic signed [21:0] cur,
                                                  input logic signed [21:0] goal,
                                                  input logic [15:0] step);
    logic signed [22:0] d;
    logic [22:0]        mag;
    logic signed [21:0] st;
    d   = 23'(goal) - 23'(cur);
    mag = (d < 0) ? 23'(-d) : 23'(d);
    st  = signed'({6'd0, step});
    if (mag <= {7'd0, step}) begin
      return goal;
    end else if (d > 0) begin
      return cur + st;
    end else begin
      return cur - st;
    end
  endfunction

endpackage

### hdl/scara_ik_joint_motion_controller.sv
// Channel | Handshake            | Words carried
// cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (register write)
// in      | in_valid/in_stall    | in_op, in_cmd_x/y/z/yaw, in_cmd_grip
// out     | out_valid/out_stall  | reachable, joint positions, tool pose
//
// One word is processed at a time; in_stall is high from acceptance until the result is stored.
// Sine/cosine passes reduce a large angle by repeated subtraction of 2*pi before iterating. The
// single serial CORDIC unit sets most of the time from acceptance to out_valid, beside the serial
// divider and square root. Synchronous active-low reset clears positions and goals and loads the
// configuration registers with their defaults; a result waiting on out_stall does not block
// acceptance of the next word, only the storing of the one after it.
module scara_ik_joint_motion_controller
  import scik_pkg::*;
#(
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [20:0] in_cmd_x,
  input  logic signed [20:0] in_cmd_y,
  input  logic signed [20:0] in_cmd_z,
  input  logic signed [20:0] in_cmd_yaw,
  input  logic               in_cmd_grip,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_reachable,
  output logic signed [20:0] out_shoulder,
  output logic signed [20:0] out_elbow,
  output logic signed [20:0] out_quill,
  output logic signed [20:0] out_wrist,
  output logic [15:0]        out_gripper,
  output logic signed [20:0] out_tool_x,
  output logic signed [20:0] out_tool_y,
  output logic signed [20:0] out_tool_z,
  output logic signed [20:0] out_tool_yaw
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = 38 + FRAC_BITS;
  localparam int VW = 2 * FRAC_BITS + 1;
  localparam logic signed [55:0] RND_F  = 56'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [55:0] RND_30 = 56'sd1 <<< 29;

  // configuration
  logic [17:0] link1_r, link2_r;
  logic [15:0] rot_step_r, lin_step_r, grip_step_r, grip_travel_r;

  st_t        state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  logic               op_r, grip_r;
  logic signed [20:0] x_r, y_r, z_r, yaw_r;

  logic signed [20:0] pos_sh_r, pos_el_r, pos_qu_r, pos_wr_r;
  logic [15:0]        pos_gr_r;
  logic signed [20:0] goal_sh_r, goal_el_r, goal_qu_r, goal_wr_r;
  logic               goal_gr_r;

  logic signed [55:0] acc_r, prod_r;
  logic [35:0]        hden_r;
  logic               numneg_r, ok_r;
  logic [DW-1:0]      rem_r, dsh_r;
  logic [QW-1:0]      q_r;
  logic [VW-1:0]      v_r, bit_r;
  logic [VW:0]        root_r;
  logic signed [21:0] k1_r, k2_r, el_r, t1_r;
  logic signed [22:0] sh_r;
  logic signed [32:0] c1_r, s1_r, c12_r, s12_r;
  logic signed [20:0] tx_r, ty_r;

  logic               out_valid_r, reach_o_r;
  logic signed [20:0] o_sh_r, o_el_r, o_qu_r, o_wr_r, o_tx_r, o_ty_r, o_yaw_r;
  logic [15:0]        o_gr_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [QW:0] c2;
  logic signed [55:0] mag, prnd_f;
  logic [36:0]        den;
  logic [VW:0]        sq_t;
  logic               reach, load_out;

  cord_req_t          creq;
  logic signed [21:0] cx, cy, c_ang;
  logic signed [22:0] cang;
  logic               c_done;
  logic signed [32:0] c_cos, c_sin;

  scik_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (creq),
    .x_in    (cx),
    .y_in    (cy),
    .ang_in  (cang),
    .done    (c_done),
    .angle   (c_ang),
    .cos_out (c_cos),
    .sin_out (c_sin)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign mul_full  = mul_a * mul_b;
  assign c2        = numneg_r ? -signed'({1'b0, q_r}) : signed'({1'b0, q_r});
  assign mag       = (acc_r < 0) ? -acc_r : acc_r;
  assign den       = {hden_r, 1'b0};
  assign reach     = (hden_r != '0) && (mag <= signed'(56'(den)));
  assign prnd_f    = (prod_r + RND_F) >>> FRAC_BITS;
  assign sq_t      = root_r + (VW + 1)'(bit_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    mul_a     = '0;
    mul_b     = '0;
    creq      = '0;
    cx        = '0;
    cy        = '0;
    cang      = '0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) begin
          state_nxt = in_op ? ST_TICK : ST_NUM;
        end
      end
      ST_TICK: state_nxt = ST_ROT1;
      ST_NUM: begin
        case (step_r)
          5'd0: begin mul_a = 33'(x_r); mul_b = 33'(x_r); end
          5'd1: begin mul_a = 33'(y_r); mul_b = 33'(y_r); end
          5'd2: begin mul_a = signed'(33'(link1_r)); mul_b = signed'(33'(link1_r)); end
          5'd3: begin mul_a = signed'(33'(link2_r)); mul_b = signed'(33'(link2_r)); end
          5'd4: begin mul_a = signed'(33'(link1_r)); mul_b = signed'(33'(link2_r)); end
          default: ;
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd5) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        step_nxt  = '0;
        state_nxt = reach ? ST_DIV : ST_ROT1;
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(FRAC_BITS)) begin
          step_nxt  = '0;
          state_nxt = ST_C2SQ;
        end
      end
      ST_C2SQ: begin
        mul_a    = 33'(c2);
        mul_b    = 33'(c2);
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd1) begin
          step_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(FRAC_BITS)) begin
          step_nxt  = '0;
          state_nxt = ST_KMUL;
        end
      end
      ST_KMUL: begin
        mul_a = signed'(33'(link2_r));
        mul_b = (step_r == 5'd0) ? 33'(c2) : signed'(33'(root_r[QW-1:0]));
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd2) begin
          step_nxt  = '0;
          state_nxt = ST_ATAN_EL;
        end
      end
      ST_ATAN_EL, ST_ATAN_T1, ST_ATAN_T2: begin
        case (state_r)
          ST_ATAN_EL: begin cx = 22'(c2); cy = signed'(22'(root_r[QW-1:0])); end
          ST_ATAN_T1: begin cx = 22'(x_r); cy = 22'(y_r); end
          default:    begin cx = k1_r; cy = k2_r; end
        endcase
        if (step_r == 5'd0) begin
          creq.start = 1'b1;
          step_nxt   = 5'd1;
        end else if (c_done) begin
          step_nxt = '0;
          case (state_r)
            ST_ATAN_EL: state_nxt = ST_ATAN_T1;
            ST_ATAN_T1: state_nxt = ST_ATAN_T2;
            default:    state_nxt = ST_GOAL;
          endcase
        end
      end
      ST_GOAL: state_nxt = ST_ROT1;
      ST_ROT1, ST_ROT2: begin
        creq.rotate = 1'b1;
        cang = (state_r == ST_ROT1) ? 23'(pos_sh_r) : 23'(pos_sh_r) + 23'(pos_el_r);
        if (step_r == 5'd0) begin
          creq.start = 1'b1;
          step_nxt   = 5'd1;
        end else if (c_done) begin
          step_nxt  = '0;
          state_nxt = (state_r == ST_ROT1) ? ST_ROT2 : ST_FKMUL;
        end
      end
      ST_FKMUL: begin
        case (step_r)
          5'd0: begin mul_a = signed'(33'(link1_r)); mul_b = c1_r; end
          5'd1: begin mul_a = signed'(33'(link2_r)); mul_b = c12_r; end
          5'd2: begin mul_a = signed'(33'(link1_r)); mul_b = s1_r; end
          5'd3: begin mul_a = signed'(33'(link2_r)); mul_b = s12_r; end
          default: ;
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd5) begin
          step_nxt  = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link1_r       <= LINK1_RST;
      link2_r       <= LINK2_RST;
      rot_step_r    <= ROT_STEP_RST;
      lin_step_r    <= LIN_STEP_RST;
      grip_step_r   <= GRIP_STEP_RST;
      grip_travel_r <= GRIP_TRAVEL_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LINK1:       link1_r       <= cfg_data;
        CFG_LINK2:       link2_r       <= cfg_data;
        CFG_ROT_STEP:    rot_step_r    <= cfg_data[15:0];
        CFG_LIN_STEP:    lin_step_r    <= cfg_data[15:0];
        CFG_GRIP_STEP:   grip_step_r   <= cfg_data[15:0];
        CFG_GRIP_TRAVEL: grip_travel_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Joint positions and goals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_sh_r  <= '0;
      pos_el_r  <= '0;
      pos_qu_r  <= '0;
      pos_wr_r  <= '0;
      pos_gr_r  <= '0;
      goal_sh_r <= '0;
      goal_el_r <= '0;
      goal_qu_r <= '0;
      goal_wr_r <= '0;
      goal_gr_r <= 1'b0;
    end else if (state_r == ST_TICK) begin
      pos_sh_r <= 21'(approach(22'(pos_sh_r), 22'(goal_sh_r), rot_step_r));
      pos_el_r <= 21'(approach(22'(pos_el_r), 22'(goal_el_r), rot_step_r));
      pos_qu_r <= 21'(approach(22'(pos_qu_r), 22'(goal_qu_r), lin_step_r));
      pos_wr_r <= 21'(approach(22'(pos_wr_r), 22'(goal_wr_r), rot_step_r));
      pos_gr_r <= 16'(approach(signed'(22'(pos_gr_r)),
                               goal_gr_r ? signed'(22'(grip_travel_r)) : 22'sd0,
                               grip_step_r));
    end else if (state_r == ST_GOAL) begin
      goal_sh_r <= sat21(56'(sh_r));
      goal_el_r <= sat21(56'(el_r));
      goal_wr_r <= sat21(56'(yaw_r) - 56'(sh_r) - 56'(el_r));
      goal_qu_r <= z_r;
      goal_gr_r <= grip_r;
    end
  end

  // Working registers of the solver and of the pose calculation.
  always_ff @(posedge clk) begin
    prod_r <= signed'(mul_full[55:0]);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_r   <= in_op;
          x_r    <= in_cmd_x;
          y_r    <= in_cmd_y;
          z_r    <= in_cmd_z;
          yaw_r  <= in_cmd_yaw;
          grip_r <= in_cmd_grip;
        end
      end
      ST_TICK: ok_r <= 1'b1;
      ST_NUM: begin
        case (step_r)
          5'd1: acc_r <= prod_r;
          5'd2: acc_r <= acc_r + prod_r;
          5'd3: acc_r <= acc_r - prod_r;
          5'd4: acc_r <= acc_r - prod_r;
          5'd5: hden_r <= prod_r[35:0];
          default: ;
        endcase
      end
      ST_CHK: begin
        ok_r     <= reach;
        numneg_r <= (acc_r < 0);
        rem_r    <= (DW'(mag[36:0]) << FRAC_BITS) + DW'(hden_r);
        dsh_r    <= DW'(den) << FRAC_BITS;
        q_r      <= '0;
      end
      ST_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      ST_C2SQ: begin
        if (step_r == 5'd1) begin
          v_r    <= (VW'(1) << (2 * FRAC_BITS)) - VW'(prod_r[VW-1:0]);
          root_r <= '0;
          bit_r  <= VW'(1) << (2 * FRAC_BITS);
        end
      end
      ST_SQRT: begin
        if ((VW + 1)'(v_r) >= sq_t) begin
          v_r    <= v_r - VW'(sq_t);
          root_r <= (root_r >> 1) + (VW + 1)'(bit_r);
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_KMUL: begin
        if (step_r == 5'd1) begin
          k1_r <= 22'(prnd_f + signed'(56'(link1_r)));
        end else if (step_r == 5'd2) begin
          k2_r <= 22'(prnd_f);
        end
      end
      ST_ATAN_EL: if (c_done) el_r <= c_ang;
      ST_ATAN_T1: if (c_done) t1_r <= c_ang;
      ST_ATAN_T2: if (c_done) sh_r <= 23'(t1_r) - 23'(c_ang);
      ST_GOAL:    ok_r <= 1'b1;
      ST_ROT1: begin
        if (c_done) begin
          c1_r <= c_cos;
          s1_r <= c_sin;
        end
      end
      ST_ROT2: begin
        if (c_done) begin
          c12_r <= c_cos;
          s12_r <= c_sin;
        end
      end
      ST_FKMUL: begin
        case (step_r)
          5'd1: acc_r <= prod_r;
          5'd2: acc_r <= acc_r + prod_r;
          5'd3: begin
            tx_r  <= sat21((acc_r + RND_30) >>> 30);
            acc_r <= prod_r;
          end
          5'd4: acc_r <= acc_r + prod_r;
          5'd5: ty_r  <= sat21((acc_r + RND_30) >>> 30);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      reach_o_r <= ok_r | op_r;
      o_sh_r    <= pos_sh_r;
      o_el_r    <= pos_el_r;
      o_qu_r    <= pos_qu_r;
      o_wr_r    <= pos_wr_r;
      o_gr_r    <= pos_gr_r;
      o_tx_r    <= tx_r;
      o_ty_r    <= ty_r;
      o_yaw_r   <= sat21(56'(pos_sh_r) + 56'(pos_el_r) + 56'(pos_wr_r));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_reachable = reach_o_r;
  assign out_shoulder  = o_sh_r;
  assign out_elbow     = o_el_r;
  assign out_quill     = o_qu_r;
  assign out_wrist     = o_wr_r;
  assign out_gripper   = o_gr_r;
  assign out_tool_x    = o_tx_r;
  assign out_tool_y    = o_ty_r;
  assign out_tool_z    = o_qu_r;
  assign out_tool_yaw  = o_yaw_r;

endmodule

### hdl/scik_cordic.sv
module scik_cordic
  import scik_pkg::*;
#(
  parameter int ITERS = CORDIC_ITERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cord_req_t          req,
  input  logic signed [21:0] x_in,
  input  logic signed [21:0] y_in,
  input  logic signed [22:0] ang_in,
  output logic               done,
  output logic signed [21:0] angle,
  output logic signed [32:0] cos_out,
  output logic signed [32:0] sin_out
);

  localparam int IW = $clog2(ATAN_LEN + 1);
  localparam logic signed [ZW-1:0] ANG_HALF = ZW'(1) <<< (ANG_SHIFT - 1);

  cst_t                 st_r, st_nxt;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 neg_r, neg_nxt, rot_r, rot_nxt;
  logic [IW-1:0]        it_r, it_nxt;

  logic signed [XW-1:0] xs, ys, shx, shy;
  logic signed [ZW-1:0] at;
  logic                 ccw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
    rot_r <= rot_nxt;
    it_r  <= it_nxt;
  end

  always_comb begin
    st_nxt  = st_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    neg_nxt = neg_r;
    rot_nxt = rot_r;
    it_nxt  = it_r;
    done    = 1'b0;
    xs      = XW'(x_in) <<< 20;
    ys      = XW'(y_in) <<< 20;
    shx     = x_r >>> it_r;
    shy     = y_r >>> it_r;
    at      = signed'(ZW'(atan_q30(5'(it_r))));
    // Rotation mode steers on the residual angle, vectoring on the sign of y.
    ccw     = rot_r ? (z_r >= 0) : (y_r <= 0);
    case (st_r)
      C_IDLE: begin
        if (req.start) begin
          rot_nxt = req.rotate;
          neg_nxt = 1'b0;
          it_nxt  = '0;
          if (req.rotate) begin
            z_nxt  = ZW'(ang_in) <<< ANG_SHIFT;
            st_nxt = C_REDUCE;
          end else if (x_in == 0 && y_in == 0) begin
            x_nxt  = '0;
            y_nxt  = '0;
            z_nxt  = '0;
            st_nxt = C_DONE;
          end else if (x_in < 0) begin
            z_nxt  = (y_in >= 0) ? PI_Q30 : -PI_Q30;
            x_nxt  = -xs;
            y_nxt  = -ys;
            st_nxt = C_ITER;
          end else begin
            z_nxt  = '0;
            x_nxt  = xs;
            y_nxt  = ys;
            st_nxt = C_ITER;
          end
        end
      end
      C_REDUCE: begin
        // Remainder by two pi, truncated toward zero.
        if (z_r >= TWO_PI_Q30) begin
          z_nxt = z_r - TWO_PI_Q30;
        end else if (z_r <= -TWO_PI_Q30) begin
          z_nxt = z_r + TWO_PI_Q30;
        end else begin
          st_nxt = C_WRAP;
        end
      end
      C_WRAP: begin
        if (z_r > PI_Q30) begin
          z_nxt = z_r - TWO_PI_Q30;
        end else if (z_r < -PI_Q30) begin
          z_nxt = z_r + TWO_PI_Q30;
        end
        st_nxt = C_FOLD;
      end
      C_FOLD: begin
        if (z_r > HALF_PI_Q30) begin
          z_nxt   = z_r - PI_Q30;
          neg_nxt = 1'b1;
        end else if (z_r < -HALF_PI_Q30) begin
          z_nxt   = z_r + PI_Q30;
          neg_nxt = 1'b1;
        end
        x_nxt  = GAIN_Q30;
        y_nxt  = '0;
        st_nxt = C_ITER;
      end
      C_ITER: begin
        if (ccw) begin
          x_nxt = x_r - shy;
          y_nxt = y_r + shx;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + shy;
          y_nxt = y_r - shx;
          z_nxt = z_r + at;
        end
        if (it_r == IW'(ITERS - 1)) begin
          st_nxt = C_DONE;
        end else begin
          it_nxt = it_r + 1'b1;
        end
      end
      C_DONE: begin
        done   = 1'b1;
        st_nxt = C_IDLE;
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  assign angle   = 22'((z_r + ANG_HALF) >>> ANG_SHIFT);
  assign cos_out = 33'(neg_r ? -x_r : x_r);
  assign sin_out = 33'(neg_r ? -y_r : y_r);

endmodule

### hdl/scik_checker.sv
module scik_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [20:0] out_quill,
  input logic signed [20:0] out_tool_z
);

  // Once a word is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a word was accepted");

  // A new result appears only as the sequencer returns to idle.
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while still busy");

  a_tool_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tool_z == out_quill)
    else $error("tool height differs from quill position");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quill))
    else $error("stalled result dropped or changed");

endmodule

bind scara_ik_joint_motion_controller scik_checker u_scik_checker (.*);
